@@ rtl/sorted_list_table_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list table unit
// Both macros sample on clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_UNIT_DEFINES_SVH
`define SORTED_LIST_TABLE_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define SLT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// Sizes, operation and status codes and word types of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

   // Table size and derived index and count widths
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // Fixed field widths of the words
   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int ST_W    = 2;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]           status;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      last;
   } rsp_type;

endpackage

@@ rtl/sorted_list_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Ascending table of signed 32-bit values with insert, remove, search and
// dump, run by a small sequencer around one table RAM and one comparator.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Word
//   req       in    req_valid / req_stall  req_data  (operation, value)
//   rsp       out   rsp_valid / rsp_stall  rsp_data  (status ... last)
//
// Insert walks down from the top entry, moving each larger or equal entry up one
// place; remove and search walk up from entry 0. One entry per cycle, set by
// the single read port of the table RAM.
// Dump gives one word per cycle when rsp is not stalled.
// Reset clears the count and the sequencer; the RAM contents are not cleared.
// A stalled rsp word holds; dump pauses while rsp is stalled.
// ----------------------------------------------------------------------------
module sorted_list_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slt_pkg::rsp_type rsp_data
);

   localparam int IDX_W   = slt_pkg::IDX_W;
   localparam int CNT_W   = slt_pkg::CNT_W;
   localparam int POS_W   = slt_pkg::POS_W;
   localparam int COUNT_W = slt_pkg::COUNT_W;
   localparam int VALUE_W = slt_pkg::VALUE_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_DUMP  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [slt_pkg::OP_W-1:0]   op_ff;
   logic signed [VALUE_W-1:0]  val_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [slt_pkg::ST_W-1:0]   status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   slt_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Table RAM
   logic signed [VALUE_W-1:0]  mem [slt_pkg::DEPTH];
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic signed [VALUE_W-1:0]  rd_data_ff;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic signed [VALUE_W-1:0]  wr_data;

   logic                       accept;
   logic                       out_free;
   logic                       lt;
   logic                       eq;
   logic [IDX_W-1:0]           last_idx;
   logic                       j_is_last;
   logic [IDX_W-1:0]           j_plus;
   logic [IDX_W-1:0]           j_minus;
   logic                       count_full;
   logic                       count_zero;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared comparator against the operand
   assign lt = (rd_data_ff < val_ff);
   assign eq = (rd_data_ff == val_ff);

   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign j_is_last  = (j_ff == last_idx);
   assign j_plus     = j_ff + IDX_W'(1);
   assign j_minus    = j_ff - IDX_W'(1);
   assign count_full = (count_ff == CNT_W'(slt_pkg::DEPTH));
   assign count_zero = (count_ff == '0);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rd_en        = 1'b0;
      rd_addr      = j_ff;
      wr_en        = 1'b0;
      wr_addr      = j_ff;
      wr_data      = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end

         // Pick the walk direction and issue the first read
         S_START: begin
            pos_in    = '0;
            status_in = slt_pkg::ST_OK;
            case (op_ff)
               slt_pkg::OP_INSERT: begin
                  if (count_full) begin
                     status_in = slt_pkg::ST_FULL;
                     state_in  = S_RESP;
                  end else if (count_zero) begin
                     state_in = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = last_idx;
                     j_in     = last_idx;
                     state_in = S_INS;
                  end
               end
               slt_pkg::OP_REMOVE, slt_pkg::OP_SEARCH: begin
                  if (count_zero) begin
                     status_in = slt_pkg::ST_NOTFOUND;
                     state_in  = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     j_in     = '0;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (count_zero) begin
                     status_in = slt_pkg::ST_EMPTY;
                     state_in  = S_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     j_in     = '0;
                     state_in = S_DUMP;
                  end
               end
            endcase
         end

         // Move larger or equal entries up until a smaller one or the bottom is reached
         S_INS: begin
            if (lt) begin
               pos_in   = j_plus;
               state_in = S_RESP;
            end else begin
               wr_en   = 1'b1;
               wr_addr = j_plus;
               wr_data = rd_data_ff;
               if (j_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_minus;
                  j_in    = j_minus;
               end
            end
         end

         // Look for the first equal entry
         S_SCAN: begin
            if (eq) begin
               pos_in = j_ff;
               if (op_ff == slt_pkg::OP_SEARCH || j_is_last) begin
                  state_in = S_RESP;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = j_plus;
                  j_in     = j_plus;
                  state_in = S_SHIFT;
               end
            end else if (j_is_last) begin
               status_in = slt_pkg::ST_NOTFOUND;
               pos_in    = '0;
               state_in  = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = j_plus;
               j_in    = j_plus;
            end
         end

         // Close the gap left by the removed entry
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = j_minus;
            wr_data = rd_data_ff;
            if (j_is_last) begin
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = j_plus;
               j_in    = j_plus;
            end
         end

         // Emit one entry per free output slot
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = slt_pkg::ST_OK;
               rsp_data_in.position    = POS_W'(j_ff);
               rsp_data_in.entry_value = rd_data_ff;
               rsp_data_in.entry_count = COUNT_W'(count_ff);
               rsp_data_in.last        = j_is_last;
               if (j_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_plus;
                  j_in    = j_plus;
               end
            end
         end

         // Store the inserted value, update the count and give the result
         S_RESP: begin
            if (op_ff == slt_pkg::OP_INSERT && status_ff == slt_pkg::ST_OK) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = val_ff;
            end
            if (out_free) begin
               if (status_ff == slt_pkg::ST_OK && op_ff == slt_pkg::OP_INSERT) begin
                  count_in = count_ff + CNT_W'(1);
               end else if (status_ff == slt_pkg::ST_OK && op_ff == slt_pkg::OP_REMOVE) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.position    = POS_W'(pos_ff);
               rsp_data_in.entry_value = (op_ff == slt_pkg::OP_DUMP) ? '0 : val_ff;
               rsp_data_in.entry_count = COUNT_W'(count_in);
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.operation;
         val_ff <= req_data.value;
      end
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table RAM: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/slt_checker.sv @@
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks of the sorted list table unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_list_table_unit_defines.svh"

module slt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input slt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input slt_pkg::rsp_type rsp_data
);

   localparam int COUNT_W = slt_pkg::COUNT_W;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(slt_pkg::DEPTH);

   logic req_word_taken;
   logic rsp_full_word;
   logic rsp_empty_word;
   logic rsp_miss_word;

   assign req_word_taken = req_valid && !req_stall;
   assign rsp_full_word  = rsp_valid && (rsp_data.status == slt_pkg::ST_FULL);
   assign rsp_empty_word = rsp_valid && (rsp_data.status == slt_pkg::ST_EMPTY);
   assign rsp_miss_word  = rsp_valid && (rsp_data.status == slt_pkg::ST_NOTFOUND);

   // Hold a stalled result word
   `SLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // Go busy once a word is taken
   `SLT_ASSERT_NEXT(a_busy_after_take, req_word_taken, req_stall, "req taken again without pause")

   // Refuse an insert only with a full table
   `SLT_ASSERT_SAME(a_full_count, rsp_full_word, rsp_data.entry_count == FULL_COUNT && rsp_data.last, "full status with table not full")

   // Report empty only with no entries
   `SLT_ASSERT_SAME(a_empty_count, rsp_empty_word, rsp_data.entry_count == '0 && rsp_data.last && rsp_data.position == '0, "empty status with entries present")

   // Give position zero on a miss
   `SLT_ASSERT_SAME(a_miss_pos, rsp_miss_word, rsp_data.position == '0 && rsp_data.last, "miss with nonzero position")

endmodule

bind sorted_list_table_unit slt_checker u_slt_checker (.*);
